[src/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge of clk while rst is low.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising edge of clk, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[src/iirdf1_pkg.sv]
// ----------------------------------------------------------------------------
// Direct form I IIR filter package
// Widths, register indexes and shared types of the filter.
// ----------------------------------------------------------------------------
package iirdf1_pkg;

  localparam int SAMPLE_W = 16;
  localparam int COEF_W = 20;
  localparam int PROD_W = SAMPLE_W + COEF_W;
  localparam int ACC_W = PROD_W + 3;
  localparam int FRAC_SHIFT = 14;
  localparam int HIST_DEPTH = 3;
  localparam int SAMPLE_MAX = 32767;
  localparam int SAMPLE_MIN = -32768;
  localparam int CFG_IDX_W = 3;
  localparam int B0_RESET = 16384;

  localparam int FEED_FORWARD_TAPS_DEF = 4;
  localparam int FEEDBACK_TAPS_DEF = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_B0,
    REG_B1,
    REG_B2,
    REG_B3,
    REG_A1,
    REG_A2,
    REG_A3
  } reg_idx_t;

  typedef enum logic {
    KIND_FILTER = 1'b0,
    KIND_CLEAR  = 1'b1
  } kind_t;

  typedef struct packed {
    logic                     b_we;
    logic                     a_we;
    logic signed [COEF_W-1:0] data;
  } cfg_wr_t;

  typedef struct packed {
    logic shift;
    logic clear;
  } step_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       sat;
  } result_t;

endpackage

[src/iirdf1_cell.sv]
// ----------------------------------------------------------------------------
// IIR filter history cell
// Holds one past input, one past output and their two coefficients, adds the
// x term to the sum, subtracts the y term, hands its history to the next cell.
// ----------------------------------------------------------------------------
module iirdf1_cell #(
  parameter bit USE_B = 1'b1,
  parameter bit USE_A = 1'b1
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  iirdf1_pkg::cfg_wr_t                      cfg,
  input  iirdf1_pkg::step_t                        step,
  input  logic signed [iirdf1_pkg::SAMPLE_W-1:0]   x_in,
  input  logic signed [iirdf1_pkg::SAMPLE_W-1:0]   y_in,
  output logic signed [iirdf1_pkg::SAMPLE_W-1:0]   x_out,
  output logic signed [iirdf1_pkg::SAMPLE_W-1:0]   y_out,
  input  logic signed [iirdf1_pkg::ACC_W-1:0]      sum_in,
  output logic signed [iirdf1_pkg::ACC_W-1:0]      sum_out
);

  logic signed [iirdf1_pkg::COEF_W-1:0]   coef_b;
  logic signed [iirdf1_pkg::COEF_W-1:0]   coef_a;
  logic signed [iirdf1_pkg::SAMPLE_W-1:0] x_hist;
  logic signed [iirdf1_pkg::SAMPLE_W-1:0] y_hist;
  logic signed [iirdf1_pkg::PROD_W-1:0]   prod_b;
  logic signed [iirdf1_pkg::PROD_W-1:0]   prod_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_b <= '0;
      coef_a <= '0;
      x_hist <= '0;
      y_hist <= '0;
    end else begin
      if (cfg.b_we) begin
        coef_b <= cfg.data;
      end
      if (cfg.a_we) begin
        coef_a <= cfg.data;
      end
      if (step.shift) begin
        x_hist <= step.clear ? '0 : x_in;
        y_hist <= step.clear ? '0 : y_in;
      end
    end
  end

  always_comb begin
    prod_b = '0;
    prod_a = '0;
    if (USE_B) begin
      prod_b = coef_b * x_hist;
    end
    if (USE_A) begin
      prod_a = coef_a * y_hist;
    end
    sum_out = sum_in + iirdf1_pkg::ACC_W'(prod_b) - iirdf1_pkg::ACC_W'(prod_a);
  end

  assign x_out = x_hist;
  assign y_out = y_hist;

endmodule

[src/iirdf1_round.sv]
// ----------------------------------------------------------------------------
// IIR filter output rounding
// Rounds the accumulator to nearest, ties up, and clips it to 16 bits.
// ----------------------------------------------------------------------------
module iirdf1_round (
  input  logic signed [iirdf1_pkg::ACC_W-1:0]    acc,
  output logic signed [iirdf1_pkg::SAMPLE_W-1:0] sample,
  output logic                                   sat
);

  localparam logic signed [iirdf1_pkg::ACC_W-1:0] HALF =
    iirdf1_pkg::ACC_W'(1 << (iirdf1_pkg::FRAC_SHIFT - 1));
  localparam logic signed [iirdf1_pkg::ACC_W-1:0] LIM_HI =
    iirdf1_pkg::ACC_W'(iirdf1_pkg::SAMPLE_MAX);
  localparam logic signed [iirdf1_pkg::ACC_W-1:0] LIM_LO =
    iirdf1_pkg::ACC_W'(iirdf1_pkg::SAMPLE_MIN);

  logic signed [iirdf1_pkg::ACC_W-1:0] biased;
  logic signed [iirdf1_pkg::ACC_W-1:0] rounded;

  always_comb begin
    biased  = acc + HALF;
    rounded = biased >>> iirdf1_pkg::FRAC_SHIFT;
    if (rounded > LIM_HI) begin
      sample = iirdf1_pkg::SAMPLE_W'(iirdf1_pkg::SAMPLE_MAX);
      sat    = 1'b1;
    end else if (rounded < LIM_LO) begin
      sample = iirdf1_pkg::SAMPLE_W'(iirdf1_pkg::SAMPLE_MIN);
      sat    = 1'b1;
    end else begin
      sample = rounded[iirdf1_pkg::SAMPLE_W-1:0];
      sat    = 1'b0;
    end
  end

endmodule

[src/iirdf1_outbuf.sv]
// ----------------------------------------------------------------------------
// IIR filter output buffer
// Output register with a skid stage, so a new item is taken while the
// previous result still waits downstream.
// ----------------------------------------------------------------------------
module iirdf1_outbuf (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  iirdf1_pkg::result_t in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output iirdf1_pkg::result_t out_data
);

  logic                skid_valid;
  iirdf1_pkg::result_t skid_data;

  assign in_ready = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      priority if (skid_valid) begin
        if (out_ready) begin
          out_data   <= skid_data;
          skid_valid <= 1'b0;
        end
      end else if (in_valid) begin
        if (!out_valid || out_ready) begin
          out_data  <= in_data;
          out_valid <= 1'b1;
        end else begin
          skid_data  <= in_data;
          skid_valid <= 1'b1;
        end
      end else begin
        if (out_ready) begin
          out_valid <= 1'b0;
        end
      end
    end
  end

endmodule

[src/iir_direct_form_one.sv]
// A result is registered in the output buffer, or in its skid stage while the master
// side stalls. Throughput: one item per cycle while the skid stage is empty; the
// feedback path from the output history through the tap multipliers, the cell sum
// chain, rounding and clipping is combinational. Reset clears both histories, loads
// b0 with 1.0 and every other coefficient with zero, and empties the output stage.
// ----------------------------------------------------------------------------
// Direct form I IIR filter
// Four feed-forward and three feedback taps in a row of history cells, with
// rounding, clipping and a buffered stream output.
// ----------------------------------------------------------------------------
module iir_direct_form_one #(
  parameter int FEED_FORWARD_TAPS = iirdf1_pkg::FEED_FORWARD_TAPS_DEF,
  parameter int FEEDBACK_TAPS     = iirdf1_pkg::FEEDBACK_TAPS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [iirdf1_pkg::SAMPLE_W-1:0]      s_axis_tdata,  // [15:0] sample_in
  input  logic                                 s_axis_tuser,  // [0] kind
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [iirdf1_pkg::SAMPLE_W-1:0]      m_axis_tdata,  // [15:0] sample_out
  output logic                                 m_axis_tuser,  // [0] saturated
  input  logic                                 cfg_we,
  input  logic [iirdf1_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [iirdf1_pkg::COEF_W-1:0]        cfg_data
);

  localparam int DEPTH = iirdf1_pkg::HIST_DEPTH;

  logic                                   accept;
  logic                                   is_clear;
  iirdf1_pkg::step_t                      step;
  logic signed [iirdf1_pkg::COEF_W-1:0]   coef_b0;
  logic signed [iirdf1_pkg::SAMPLE_W-1:0] x_new;
  logic signed [iirdf1_pkg::PROD_W-1:0]   prod_b0;
  logic signed [iirdf1_pkg::SAMPLE_W-1:0] y_round;
  logic                                   y_sat;
  iirdf1_pkg::result_t                    result;
  iirdf1_pkg::result_t                    out_res;

  logic signed [iirdf1_pkg::SAMPLE_W-1:0] x_link   [0:DEPTH];
  logic signed [iirdf1_pkg::SAMPLE_W-1:0] y_link   [0:DEPTH];
  logic signed [iirdf1_pkg::ACC_W-1:0]    sum_link [0:DEPTH];

  assign accept     = s_axis_tvalid && s_axis_tready;
  assign is_clear   = (s_axis_tuser == iirdf1_pkg::KIND_CLEAR);
  assign step.shift = accept;
  assign step.clear = is_clear;
  assign x_new      = s_axis_tdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_b0 <= iirdf1_pkg::COEF_W'(iirdf1_pkg::B0_RESET);
    end else if (cfg_we && (cfg_index == iirdf1_pkg::REG_B0)) begin
      coef_b0 <= cfg_data;
    end
  end

  assign prod_b0     = coef_b0 * x_new;
  assign sum_link[0] = iirdf1_pkg::ACC_W'(prod_b0);
  assign x_link[0]   = x_new;
  assign y_link[0]   = y_round;

  for (genvar k = 1; k <= DEPTH; k++) begin : g_cell
    iirdf1_pkg::cfg_wr_t cfg;

    always_comb begin
      cfg.b_we = cfg_we && (cfg_index ==
                 iirdf1_pkg::CFG_IDX_W'(int'(iirdf1_pkg::REG_B0) + k));
      cfg.a_we = cfg_we && (cfg_index ==
                 iirdf1_pkg::CFG_IDX_W'(int'(iirdf1_pkg::REG_B3) + k));
      cfg.data = cfg_data;
    end

    iirdf1_cell #(
      .USE_B (k < FEED_FORWARD_TAPS),
      .USE_A (k < FEEDBACK_TAPS)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .cfg     (cfg),
      .step    (step),
      .x_in    (x_link[k-1]),
      .y_in    (y_link[k-1]),
      .x_out   (x_link[k]),
      .y_out   (y_link[k]),
      .sum_in  (sum_link[k-1]),
      .sum_out (sum_link[k])
    );
  end

  iirdf1_round u_round (
    .acc    (sum_link[DEPTH]),
    .sample (y_round),
    .sat    (y_sat)
  );

  always_comb begin
    result.sample = is_clear ? '0 : y_round;
    result.sat    = is_clear ? 1'b0 : y_sat;
  end

  iirdf1_outbuf u_outbuf (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_data   (result),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (out_res)
  );

  assign m_axis_tdata = out_res.sample;
  assign m_axis_tuser = out_res.sat;

endmodule

[src/iirdf1_checker.sv]
// ----------------------------------------------------------------------------
// IIR filter port checker
// Checks the filter's stream ports over time; bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module iirdf1_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [iirdf1_pkg::SAMPLE_W-1:0]  m_axis_tdata,
  input logic                             m_axis_tuser
);

  `ASSERT_ALWAYS(a_reset_empty, rst |=> !m_axis_tvalid, "output valid right after reset")
  `ASSERT_CLK(a_stall_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")
  `ASSERT_CLK(a_busy_full, !s_axis_tready |-> m_axis_tvalid, "input held off with an empty output")
  `ASSERT_CLK(a_sat_value, m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == 16'h7fff || m_axis_tdata == 16'h8000, "saturation flag without a limit value")

endmodule

bind iir_direct_form_one iirdf1_checker u_checker (.*);
